// ----- rtl/core/dcr_pkg.sv -----
// ----------------------------------------------------------------------------
// dcr_pkg
// shared types, constants and helpers for the captive dns responder
// ----------------------------------------------------------------------------
package dcr_pkg;

  localparam int BUFFER_BYTES_DEF = 512;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int          HEADER_BYTES = 12;
  localparam int          ANSWER_BYTES = 16;
  localparam logic [15:0] QR_MASK      = 16'h8000;
  localparam logic [15:0] OPCODE_MASK  = 16'h7800;
  localparam logic [7:0]  LABEL_PTR    = 8'hC0;
  localparam logic [15:0] REPLY_FLAGS  = 16'h8400;
  localparam logic [15:0] ANSWER_PTR   = 16'hC00C;
  localparam logic [15:0] QTYPE_A      = 16'h0001;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic [9:0] reply_length;
    logic [7:0] reply_byte;
    logic       is_length;
  } result_t;

  // byte of the answer record: pointer, type A, class IN, ttl 0, rdlength 4, address
  function automatic logic [7:0] answer_byte(input logic [3:0] off, input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    case (off)
      4'd0:    b = ANSWER_PTR[15:8];
      4'd1:    b = ANSWER_PTR[7:0];
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h01;
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/dns_captive_responder.sv -----
// ----------------------------------------------------------------------------
// dns_captive_responder
// answers every dns A query with one configured address
// ----------------------------------------------------------------------------
// Usage: a command is taken on cmd at each rising edge with start high and
// busy low; busy stays low, so one command can be issued every cycle.
// OP_PUSH appends a query byte (no result), OP_BUILD closes the query and
// returns the reply length (0 means drop), OP_READ returns the reply byte at
// read_index. Header checks and the qname label walk are tracked per byte
// as the query arrives, so the build itself is a single compare-and-select
// step; the answer record is produced on the fly when read, not stored.
// Each result appears on result for one cycle with result_valid high; a
// command passes through stage one, alongside the registered query buffer
// read, and then the result register. The receiver cannot stall the block.
// answer_address is written over the cfg channel (cfg_ready always high)
// and is sampled when a reply is built.
// Reset clears the query control state and answer_address; the query buffer itself
// is not cleared, since only bytes already pushed are ever read back.
// ----------------------------------------------------------------------------
module dns_captive_responder #(
  parameter int BUFFER_BYTES = dcr_pkg::BUFFER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dcr_pkg::cmd_t   cmd,
  output logic            result_valid,
  output dcr_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import dcr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int XW = $clog2(BUFFER_BYTES + 256 + 1) + 1;

  typedef enum logic [1:0] {SRC_ZERO, SRC_MEM, SRC_CONST} src_t;

  logic [7:0] query_store [BUFFER_BYTES];

  logic [31:0]   answer_address;
  logic [31:0]   reply_address;
  logic [CW-1:0] byte_count;
  logic [XW-1:0] next_label_at;
  logic          name_complete;
  logic [AW-1:0] name_end_at;
  logic          label_error;
  logic [CW-1:0] built_length;
  logic          has_answer;
  logic          query_closed;
  logic [XW-1:0] answer_at;
  logic [15:0]   flags;
  logic [15:0]   qdcount;
  logic [15:0]   qtype;

  logic          s1_valid;
  logic          s1_is_length;
  logic [9:0]    s1_length;
  src_t          s1_src;
  logic [7:0]    s1_const;
  logic [7:0]    mem_q;

  logic          accept;
  logic          do_push;
  logic          do_build;
  logic          do_read;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign do_push   = accept && (cmd.op == OP_PUSH);
  assign do_build  = accept && (cmd.op == OP_BUILD);
  assign do_read   = accept && (cmd.op == OP_READ);

  // query state as seen by a push: a push after a build starts a new query
  logic [CW-1:0] eff_count;
  logic [XW-1:0] eff_next_label;
  logic          eff_complete;
  logic          eff_error;
  logic [AW-1:0] eff_name_end;
  logic [XW-1:0] pos_x;
  logic          push_ok;
  logic          at_label;

  always_comb begin
    eff_count      = query_closed ? '0 : byte_count;
    eff_next_label = query_closed ? XW'(HEADER_BYTES) : next_label_at;
    eff_complete   = query_closed ? 1'b0 : name_complete;
    eff_error      = query_closed ? 1'b0 : label_error;
    eff_name_end   = query_closed ? '0 : name_end_at;
    pos_x          = XW'(eff_count);
    push_ok        = eff_count < CW'(BUFFER_BYTES);
    at_label       = !eff_complete && !eff_error && (pos_x == eff_next_label);
  end

  // label walk after a push
  logic [CW-1:0] byte_count_next;
  logic [XW-1:0] next_label_at_next;
  logic          name_complete_next;
  logic [AW-1:0] name_end_at_next;
  logic          label_error_next;

  always_comb begin
    byte_count_next    = eff_count;
    next_label_at_next = eff_next_label;
    name_complete_next = eff_complete;
    name_end_at_next   = eff_name_end;
    label_error_next   = eff_error;
    if (push_ok) begin
      byte_count_next = eff_count + CW'(1);
      if (at_label) begin
        if (cmd.data_byte == 8'h00) begin
          name_complete_next = 1'b1;
          name_end_at_next   = eff_count[AW-1:0];
        end else if ((cmd.data_byte & LABEL_PTR) != 8'h00) begin
          label_error_next = 1'b1;
        end else begin
          next_label_at_next = pos_x + XW'(cmd.data_byte) + XW'(1);
        end
      end
    end
  end

  // build decision
  logic [XW-1:0] q_at;
  logic [XW-1:0] a_at;
  logic [XW-1:0] build_len;
  logic          build_answer;

  always_comb begin
    q_at         = XW'(name_end_at) + XW'(1);
    a_at         = q_at + XW'(4);
    build_len    = '0;
    build_answer = 1'b0;
    if (byte_count >= CW'(HEADER_BYTES) && (flags & QR_MASK) == 16'h0 &&
        (flags & OPCODE_MASK) == 16'h0 && qdcount == 16'h0001 &&
        name_complete && !label_error && a_at <= XW'(byte_count)) begin
      if (qtype != QTYPE_A) begin
        build_len = a_at;
      end else if (a_at + XW'(ANSWER_BYTES) <= XW'(BUFFER_BYTES)) begin
        build_len    = a_at + XW'(ANSWER_BYTES);
        build_answer = 1'b1;
      end
    end
  end

  // read source selection
  logic [XW-1:0] idx_x;
  logic [XW-1:0] rec_off;
  src_t          rd_src;
  logic [7:0]    rd_const;

  always_comb begin
    idx_x    = XW'(cmd.read_index);
    rec_off  = idx_x - answer_at;
    rd_src   = SRC_ZERO;
    rd_const = 8'h00;
    if (query_closed && idx_x < XW'(built_length)) begin
      if (has_answer && idx_x >= answer_at) begin
        rd_src   = SRC_CONST;
        rd_const = answer_byte(rec_off[3:0], reply_address);
      end else if (idx_x == XW'(2)) begin
        rd_src   = SRC_CONST;
        rd_const = REPLY_FLAGS[15:8];
      end else if (idx_x == XW'(3)) begin
        rd_src   = SRC_CONST;
        rd_const = REPLY_FLAGS[7:0];
      end else if (idx_x == XW'(6)) begin
        rd_src   = SRC_CONST;
        rd_const = 8'h00;
      end else if (idx_x == XW'(7)) begin
        rd_src   = SRC_CONST;
        rd_const = {7'd0, has_answer};
      end else begin
        rd_src = SRC_MEM;
      end
    end
  end

  // query buffer
  always_ff @(posedge clk) begin
    if (do_push && push_ok) begin
      query_store[eff_count[AW-1:0]] <= cmd.data_byte;
    end
    mem_q <= query_store[AW'(cmd.read_index)];
  end

  // header fields and qtype captured as bytes arrive
  always_ff @(posedge clk) begin
    if (do_push && push_ok) begin
      case (eff_count)
        CW'(2):  flags[15:8]   <= cmd.data_byte;
        CW'(3):  flags[7:0]    <= cmd.data_byte;
        CW'(4):  qdcount[15:8] <= cmd.data_byte;
        CW'(5):  qdcount[7:0]  <= cmd.data_byte;
        default: ;
      endcase
      if (eff_complete && pos_x == XW'(eff_name_end) + XW'(1)) begin
        qtype[15:8] <= cmd.data_byte;
      end
      if (eff_complete && pos_x == XW'(eff_name_end) + XW'(2)) begin
        qtype[7:0] <= cmd.data_byte;
      end
    end
    if (do_build && !query_closed) begin
      reply_address <= answer_address;
      answer_at     <= a_at;
    end
  end

  // query control state
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= '0;
      byte_count     <= '0;
      next_label_at  <= XW'(HEADER_BYTES);
      name_complete  <= 1'b0;
      name_end_at    <= '0;
      label_error    <= 1'b0;
      built_length   <= '0;
      has_answer     <= 1'b0;
      query_closed   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        answer_address <= cfg_data;
      end
      if (do_push) begin
        byte_count    <= byte_count_next;
        next_label_at <= next_label_at_next;
        name_complete <= name_complete_next;
        name_end_at   <= name_end_at_next;
        label_error   <= label_error_next;
        if (query_closed) begin
          built_length <= '0;
          has_answer   <= 1'b0;
          query_closed <= 1'b0;
        end
      end
      if (do_build && !query_closed) begin
        built_length <= CW'(build_len);
        has_answer   <= build_answer;
        query_closed <= 1'b1;
      end
    end
  end

  // stage one: command decoded, buffer read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_build || do_read;
    end
    s1_is_length <= do_build;
    s1_length    <= query_closed ? 10'(built_length) : 10'(build_len);
    s1_src       <= rd_src;
    s1_const     <= rd_const;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s1_valid;
    end
    result.is_length <= s1_is_length;
    if (s1_is_length) begin
      result.reply_length <= s1_length;
      result.reply_byte   <= 8'h00;
    end else begin
      result.reply_length <= 10'd0;
      case (s1_src)
        SRC_MEM:   result.reply_byte <= mem_q;
        SRC_CONST: result.reply_byte <= s1_const;
        default:   result.reply_byte <= 8'h00;
      endcase
    end
  end

endmodule

// ----- tb/dcr_reply_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_reply_check
// watches the command, result and config channels of the dns responder,
// predicts every reply length and reply byte and compares them in order
// ----------------------------------------------------------------------------
module dcr_reply_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  dcr_pkg::cmd_t    cmd,
  input  logic             result_valid,
  input  dcr_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output int               outstanding,
  output int               mismatches
);
  import dcr_pkg::*;

  localparam int STORE_BYTES = BUFFER_BYTES_DEF;

  logic [7:0]  query_bytes [STORE_BYTES];
  int unsigned bytes_held;
  int unsigned label_pos;
  int unsigned qname_end_pos;
  int unsigned reply_len;
  bit          qname_done;
  bit          qname_bad;
  bit          query_closed;
  logic [31:0] a_record_addr;
  result_t     expected_replies[$];
  int          error_count = 0;

  function automatic void clear_query();
    bytes_held    = 0;
    label_pos     = HEADER_BYTES;
    qname_done    = 1'b0;
    qname_end_pos = 0;
    qname_bad     = 1'b0;
    reply_len     = 0;
    query_closed  = 1'b0;
  endfunction

  // store one query byte and follow the qname label chain
  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned pos;
    pos = bytes_held;
    if (pos >= STORE_BYTES) return;
    query_bytes[pos] = b;
    bytes_held = pos + 1;
    if (!qname_done && !qname_bad && pos == label_pos) begin
      if (b == 8'd0) begin
        qname_done    = 1'b1;
        qname_end_pos = pos;
      end else if ((b & LABEL_PTR) != 8'd0) begin
        qname_bad = 1'b1;
      end else begin
        label_pos = pos + b + 1;
      end
    end
  endfunction

  // rewrite the stored query into the reply, returns its length or 0 for drop
  function automatic int unsigned assemble_reply();
    int unsigned   at;
    logic [15:0]   flags;
    logic [15:0]   qtype;
    logic [127:0]  a_record;
    if (bytes_held < HEADER_BYTES) return 0;
    flags = {query_bytes[2], query_bytes[3]};
    if ((flags & QR_MASK) != 16'd0 || (flags & OPCODE_MASK) != 16'd0) return 0;
    if ({query_bytes[4], query_bytes[5]} != 16'd1) return 0;
    if (!qname_done || qname_bad) return 0;
    at = qname_end_pos + 1;
    if (at + 4 > bytes_held) return 0;
    qtype = {query_bytes[at], query_bytes[at + 1]};
    at += 4;
    query_bytes[2] = REPLY_FLAGS[15:8];
    query_bytes[3] = REPLY_FLAGS[7:0];
    if (qtype != QTYPE_A) begin
      query_bytes[6] = 8'd0;
      query_bytes[7] = 8'd0;
      return at;
    end
    if (at + ANSWER_BYTES > STORE_BYTES) return 0;
    // pointer to qname, type A, class IN, ttl 0, rdlength 4, address
    a_record = {ANSWER_PTR, QTYPE_A, 16'd1, 32'd0, 16'd4, a_record_addr};
    for (int i = 0; i < ANSWER_BYTES; i++) begin
      query_bytes[at + i] = a_record[127 - 8 * i -: 8];
    end
    query_bytes[6] = 8'd0;
    query_bytes[7] = 8'd1;
    return at + ANSWER_BYTES;
  endfunction

  always @(posedge clk) begin : predict
    result_t want;
    logic [7:0] rd;
    if (rst) begin
      a_record_addr = '0;
      clear_query();
      expected_replies.delete();
    end else begin
      if (result_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result with no transaction pending: length %0d byte %02h is_length %0b",
                 result.reply_length, result.reply_byte, result.is_length);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (result.reply_length !== want.reply_length) begin
            $error("reply_length: expected %0d, got %0d", want.reply_length,
                   result.reply_length);
            error_count++;
          end
          if (result.reply_byte !== want.reply_byte) begin
            $error("reply_byte: expected %02h, got %02h", want.reply_byte,
                   result.reply_byte);
            error_count++;
          end
          if (result.is_length !== want.is_length) begin
            $error("is_length: expected %0b, got %0b", want.is_length, result.is_length);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) a_record_addr = cfg_data;
      if (start && !busy) begin
        case (cmd.op)
          OP_PUSH: begin
            if (query_closed) clear_query();
            absorb_byte(cmd.data_byte);
          end
          OP_BUILD: begin
            // a repeated end of query reports the same length again
            if (!query_closed) begin
              reply_len    = assemble_reply();
              query_closed = 1'b1;
            end
            want.reply_length = reply_len[9:0];
            want.reply_byte   = 8'd0;
            want.is_length    = 1'b1;
            expected_replies.push_back(want);
          end
          OP_READ: begin
            rd = 8'd0;
            if (query_closed && cmd.read_index < reply_len) rd = query_bytes[cmd.read_index];
            want.reply_length = '0;
            want.reply_byte   = rd;
            want.is_length    = 1'b0;
            expected_replies.push_back(want);
          end
          default: begin
          end
        endcase
      end
    end
    outstanding <= expected_replies.size();
    mismatches  <= error_count;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives dns queries, well formed and broken, into the captive responder,
// ends each one, reads the reply back and lets the checker judge the results
// ----------------------------------------------------------------------------
module tb;
  import dcr_pkg::*;

  localparam logic [1:0] OP_IDLE      = 2'd3;  // unused opcode, must be ignored
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         ITEM_TARGET  = 1700;
  localparam int         DRAIN_CYCLES = 6;

  typedef enum int {
    Q_A_GOOD, Q_OTHER_TYPE, Q_SHORT, Q_RESPONSE, Q_OPCODE, Q_QDCOUNT,
    Q_POINTER, Q_NAME_CUT, Q_TAIL_CUT, Q_NOISE, Q_LONG
  } query_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          outstanding;
  int          mismatches;

  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  logic [7:0]  query[$];
  logic [31:0] addr_plan [4] = '{32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'hFFFF_FFFF};

  always #5 clk = ~clk;

  dns_captive_responder DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  dcr_reply_check u_reply_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one command transaction, with bursty gaps unless the phase runs steady
  task automatic issue(input logic [1:0] op, input logic [7:0] data, input logic [8:0] idx);
    int gap;
    if (burst_left <= 0) begin
      if (!steady) begin
        gap = $urandom_range(1, 6);
        start <= 1'b0;
        cmd   <= cmd_t'(19'($urandom));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= '{op: op, data_byte: data, read_index: idx};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_IDLE) sent_items++;
  endtask

  // hold off until every result is back and any push has settled
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [31:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add16(input logic [15:0] v);
    query.push_back(v[15:8]);
    query.push_back(v[7:0]);
  endfunction

  function automatic void add_header(input logic [15:0] flags, input logic [15:0] qdcount);
    query.delete();
    add16(16'($urandom));
    add16(flags);
    add16(qdcount);
    repeat (3) add16(16'($urandom));
  endfunction

  function automatic void add_label(input int len);
    query.push_back(8'(len));
    repeat (len) query.push_back(8'($urandom));
  endfunction

  function automatic void add_labels(input int count);
    repeat (count) add_label(($urandom_range(0, 23) == 0) ? 63 : $urandom_range(1, 12));
  endfunction

  function automatic void add_question(input logic [15:0] qtype);
    add_labels($urandom_range(0, 4));
    query.push_back(8'd0);
    add16(qtype);
    add16(16'($urandom));
    repeat ($urandom_range(0, 6)) query.push_back(8'($urandom));
  endfunction

  function automatic void make_query(input query_kind_t kind);
    logic [15:0] good;
    logic [15:0] v;
    int          target;
    int          total;
    good = {1'b0, 4'd0, 11'($urandom)};
    case (kind)
      Q_A_GOOD: begin
        add_header(good, 16'd1);
        add_question(QTYPE_A);
      end
      Q_OTHER_TYPE: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'h0101;
          2:       v = 16'h001C;
          default: v = 16'($urandom);
        endcase
        if (v == QTYPE_A) v = 16'h00FF;
        add_header(good, 16'd1);
        add_question(v);
      end
      Q_SHORT: begin
        query.delete();
        repeat ($urandom_range(1, HEADER_BYTES - 1)) query.push_back(8'($urandom));
      end
      Q_RESPONSE: begin
        add_header(good | QR_MASK, 16'd1);
        add_question(QTYPE_A);
      end
      Q_OPCODE: begin
        add_header(good | {1'b0, 4'($urandom_range(1, 15)), 11'd0}, 16'd1);
        add_question(QTYPE_A);
      end
      Q_QDCOUNT: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'h0002;
          2:       v = 16'h0101;
          default: v = 16'($urandom);
        endcase
        if (v == 16'd1) v = 16'hFFFF;
        add_header(good, v);
        add_question(QTYPE_A);
      end
      Q_POINTER: begin
        // label length byte with one of the top two bits set, as in a compressed name
        add_header(good, 16'd1);
        add_labels($urandom_range(0, 2));
        query.push_back(8'($urandom_range(64, 255)));
        repeat ($urandom_range(0, 6)) query.push_back(8'($urandom));
        query.push_back(8'd0);
        add16(QTYPE_A);
        add16(16'd1);
      end
      Q_NAME_CUT: begin
        add_header(good, 16'd1);
        add_labels($urandom_range(1, 3));
        repeat ($urandom_range(1, query.size() - HEADER_BYTES)) void'(query.pop_back());
      end
      Q_TAIL_CUT: begin
        add_header(good, 16'd1);
        add_labels($urandom_range(0, 3));
        query.push_back(8'd0);
        repeat ($urandom_range(0, 3)) query.push_back(8'($urandom));
      end
      Q_NOISE: begin
        query.delete();
        repeat ($urandom_range(HEADER_BYTES, 48)) query.push_back(8'($urandom));
        // half the time let the header pass so the label walk sees random bytes
        if ($urandom_range(0, 1)) begin
          query[2] = 8'($urandom) & 8'h07;
          query[4] = 8'd0;
          query[5] = 8'd1;
        end
      end
      default: begin
        // either a name ending near the buffer end or a datagram past the buffer
        add_header(good, 16'd1);
        if ($urandom_range(0, 1)) begin
          target = $urandom_range(486, 507);
          while (target - query.size() > 64) add_label(63);
          if (target - query.size() >= 2) add_label(target - query.size() - 1);
        end else begin
          add_labels(2);
        end
        query.push_back(8'd0);
        add16(($urandom_range(0, 4) != 0) ? QTYPE_A : 16'h001C);
        add16(16'd1);
        total = $urandom_range(500, 540);
        while (query.size() < total) query.push_back(8'($urandom));
      end
    endcase
  endfunction

  task automatic run_query(input query_kind_t kind);
    make_query(kind);
    foreach (query[i]) begin
      // stray read or unused opcode in the middle of a query
      if ($urandom_range(0, 39) == 0) begin
        issue(($urandom_range(0, 1) != 0) ? OP_READ : OP_IDLE, 8'($urandom), 9'($urandom));
      end
      issue(OP_PUSH, query[i], 9'($urandom));
    end
    // now and then leave the query open so the next one runs on
    if ($urandom_range(0, 19) == 0) return;
    issue(OP_BUILD, 8'($urandom), 9'($urandom));
    if ($urandom_range(0, 7) == 0) issue(OP_BUILD, 8'($urandom), 9'($urandom));
    if (query.size() <= 48 && $urandom_range(0, 3) == 0) begin
      for (int i = 0; i < query.size() + 18; i++) issue(OP_READ, 8'($urandom), 9'(i));
    end else begin
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 1)) begin
          issue(OP_READ, 8'($urandom), 9'($urandom));
        end else begin
          issue(OP_READ, 8'($urandom), 9'(query.size() + 12 + $urandom_range(0, 8)));
        end
      end
    end
  endtask

  initial begin
    int phase;
    int r;
    query_kind_t kind;
    phase = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_address(32'hFFFF_FFFF);

    // reads and builds with no query, then the smallest A query
    issue(OP_READ, 8'hFF, 9'd0);
    issue(OP_IDLE, 8'h00, 9'h1FF);
    issue(OP_BUILD, 8'h00, 9'h000);
    issue(OP_BUILD, 8'hFF, 9'h1FF);
    add_header(16'h0100, 16'd1);
    query[0] = 8'hFF;
    query[1] = 8'hFF;
    query.push_back(8'd0);
    add16(QTYPE_A);
    add16(16'd1);
    foreach (query[i]) issue(OP_PUSH, query[i], 9'h1FF);
    issue(OP_BUILD, 8'h00, 9'h000);
    issue(OP_READ, 8'h00, 9'd3);
    issue(OP_READ, 8'h00, 9'd32);
    issue(OP_READ, 8'h00, 9'd33);

    // every kind of query once
    for (int k = 0; k <= Q_LONG; k++) run_query(query_kind_t'(k));

    while (sent_items < ITEM_TARGET) begin
      if (phase % 8 == 7) begin
        settle();
        write_address(((phase / 8) % 5 == 4) ? $urandom : addr_plan[(phase / 8) % 4]);
        steady = ~steady;
      end
      r = $urandom_range(0, 99);
      if (r < 40)      kind = Q_A_GOOD;
      else if (r < 55) kind = Q_OTHER_TYPE;
      else if (r < 97) kind = query_kind_t'(int'(Q_SHORT) + $urandom_range(0, 7));
      else             kind = Q_LONG;
      run_query(kind);
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dcr_pkg.sv
rtl/core/dns_captive_responder.sv
tb/dcr_reply_check.sv
tb/tb.sv
